FILE: src/sir_pkg.sv
// ----------------------------------------------------------------------------
// sir_pkg
// Shared constants and register indexes for the sparse index reshape block.
// ----------------------------------------------------------------------------
package sir_pkg;

    localparam int NUM_DIMS = 4;
    localparam int NUM_REGS = 2 * NUM_DIMS;
    localparam int ADDR_W   = 5;
    localparam int LIN_W    = 64;

    typedef enum logic [2:0] {
        REG_IN_A  = 3'd0,
        REG_IN_B  = 3'd1,
        REG_IN_C  = 3'd2,
        REG_IN_D  = 3'd3,
        REG_OUT_A = 3'd4,
        REG_OUT_B = 3'd5,
        REG_OUT_C = 3'd6,
        REG_OUT_D = 3'd7
    } reg_idx_t;

    // Side-band that travels with every item through the pipeline.
    typedef struct packed {
        logic fin;
        logic bad;
    } side_t;

endpackage

FILE: src/sparse_index_reshape_top.sv
// ----------------------------------------------------------------------------
// sparse_index_reshape_top
// Row-major index linearize / delinearize for sparse tensor coordinates.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------
//  in      | in_valid / in_ready    | pos_a..pos_d, final_entry
//  out     | out_valid / out_ready  | new_pos_a..d, final_out, bad_coord
//  cfg     | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
//  One item per cycle while the output is not stalled; linearize, then one
//  16-stage pipelined divider per output dimension (4 bits a stage), then the
//  output register. Strides settle in registers after a configuration write.
//  A stall freezes every stage in place; in_ready follows out_ready through
//  the output register. Reset clears all valid bits and sets sizes to 1.
// ----------------------------------------------------------------------------
module sparse_index_reshape_top #(
    parameter int MAX_RANK = 4,
    parameter int DIM_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sir_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [DIM_BITS-1:0]         pos_a,
    input  logic [DIM_BITS-1:0]         pos_b,
    input  logic [DIM_BITS-1:0]         pos_c,
    input  logic [DIM_BITS-1:0]         pos_d,
    input  logic                        final_entry,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [DIM_BITS-1:0]         new_pos_a,
    output logic [DIM_BITS-1:0]         new_pos_b,
    output logic [DIM_BITS-1:0]         new_pos_c,
    output logic [DIM_BITS-1:0]         new_pos_d,
    output logic                        final_out,
    output logic                        bad_coord
);

    localparam int ND    = sir_pkg::NUM_DIMS;
    localparam int W     = sir_pkg::LIN_W;
    localparam int SW    = $bits(sir_pkg::side_t);
    localparam int PAY_W = SW + MAX_RANK * DIM_BITS;

    // ---------------- configuration ----------------
    logic [MAX_RANK-1:0][DIM_BITS-1:0] in_size_reg;
    logic [MAX_RANK-1:0][DIM_BITS-1:0] out_size_reg;
    logic [MAX_RANK-1:0][W-1:0]        istr;
    logic [MAX_RANK-1:0][W-1:0]        ostr;
    logic                              cfg_wr;
    logic [2:0]                        cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < MAX_RANK; d++)
            begin
                in_size_reg[d]  <= DIM_BITS'(1);
                out_size_reg[d] <= DIM_BITS'(1);
            end
        end
        else if (cfg_wr)
        begin
            for (int k = 0; k < ND; k++)
            begin
                if (MAX_RANK - ND + k >= 0)
                begin
                    if (cfg_idx == 3'(k))
                        in_size_reg[MAX_RANK-ND+k] <= pwdata[DIM_BITS-1:0];
                    if (cfg_idx == 3'(k + ND))
                        out_size_reg[MAX_RANK-ND+k] <= pwdata[DIM_BITS-1:0];
                end
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        for (int k = 0; k < ND; k++)
        begin
            if (MAX_RANK - ND + k >= 0)
            begin
                if (cfg_idx == 3'(k))
                    prdata = 32'(in_size_reg[MAX_RANK-ND+k]);
                if (cfg_idx == 3'(k + ND))
                    prdata = 32'(out_size_reg[MAX_RANK-ND+k]);
            end
        end
    end

    sir_stride #(.MAX_RANK(MAX_RANK), .DIM_BITS(DIM_BITS)) u_istr (
        .clk(clk), .rst_n(rst_n), .size(in_size_reg), .stride(istr));
    sir_stride #(.MAX_RANK(MAX_RANK), .DIM_BITS(DIM_BITS)) u_ostr (
        .clk(clk), .rst_n(rst_n), .size(out_size_reg), .stride(ostr));

    // ---------------- pipeline control ----------------
    logic adv;
    logic ov_reg;
    assign adv      = !ov_reg || out_ready;
    assign in_ready = adv;

    // ---------------- stage 1: capture, range check, products ----------------
    logic [DIM_BITS-1:0] fpos [ND];
    assign fpos[0] = pos_a;
    assign fpos[1] = pos_b;
    assign fpos[2] = pos_c;
    assign fpos[3] = pos_d;

    logic [MAX_RANK-1:0][DIM_BITS-1:0] spos;
    logic                              bad_c;
    always_comb
    begin
        spos  = '0;
        bad_c = 1'b0;
        for (int k = 0; k < ND; k++)
            if (MAX_RANK - ND + k >= 0)
                spos[MAX_RANK-ND+k] = fpos[k];
        for (int d = 0; d < MAX_RANK; d++)
            if (spos[d] >= in_size_reg[d])
                bad_c = 1'b1;
    end

    logic                       v1_reg;
    logic [MAX_RANK-1:0][W-1:0] prod1_reg;
    sir_pkg::side_t             side1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int d = 0; d < MAX_RANK; d++)
                prod1_reg[d] <= W'(istr[d] * W'(spos[d]));
            side1_reg.fin <= final_entry;
            side1_reg.bad <= bad_c;
        end
    end

    // ---------------- stage 2: linear index sum ----------------
    logic           v2_reg;
    logic [W-1:0]   lin2_reg;
    sir_pkg::side_t side2_reg;
    logic [W-1:0]   lin_sum;

    always_comb
    begin
        lin_sum = '0;
        for (int d = 0; d < MAX_RANK; d++)
            lin_sum = W'(lin_sum + prod1_reg[d]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lin2_reg  <= side1_reg.bad ? '0 : lin_sum;
            side2_reg <= side1_reg;
        end
    end

    // ---------------- divider chain, outermost first ----------------
    logic [MAX_RANK:0]                   dv;
    logic [MAX_RANK:0][W-1:0]            drem;
    logic [MAX_RANK:0][PAY_W-1:0]        dpay;

    assign dv[0]   = v2_reg;
    assign drem[0] = lin2_reg;
    assign dpay[0] = PAY_W'(side2_reg);

    for (genvar d = 0; d < MAX_RANK; d++)
    begin : g_dim
        logic [DIM_BITS-1:0] q;
        logic [PAY_W-1:0]    pay_o;
        sir_divider #(.DIM_BITS(DIM_BITS), .STEPS_PER_STAGE(4), .PAY_W(PAY_W)) u_div (
            .clk(clk), .rst_n(rst_n), .adv(adv),
            .in_valid(dv[d]), .in_num(drem[d]), .in_div(ostr[d]), .in_pay(dpay[d]),
            .out_valid(dv[d+1]), .out_quo(q), .out_rem(drem[d+1]), .out_pay(pay_o));
        // Drop the quotient into slot d of the payload.
        always_comb
        begin
            dpay[d+1] = pay_o;
            dpay[d+1][SW + d*DIM_BITS +: DIM_BITS] = q;
        end
    end

    // ---------------- output register ----------------
    logic [MAX_RANK-1:0][DIM_BITS-1:0] npos_reg;
    sir_pkg::side_t                    oside_reg;
    sir_pkg::side_t                    fside;

    assign fside = sir_pkg::side_t'(dpay[MAX_RANK][SW-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= dv[MAX_RANK];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int d = 0; d < MAX_RANK; d++)
                npos_reg[d] <= fside.bad ? '0
                               : dpay[MAX_RANK][SW + d*DIM_BITS +: DIM_BITS];
            oside_reg <= fside;
        end
    end

    logic [DIM_BITS-1:0] onp [ND];
    always_comb
    begin
        for (int k = 0; k < ND; k++)
            onp[k] = '0;
        for (int k = 0; k < ND; k++)
            if (MAX_RANK - ND + k >= 0)
                onp[k] = npos_reg[MAX_RANK-ND+k];
    end

    assign out_valid = ov_reg;
    assign new_pos_a = onp[0];
    assign new_pos_b = onp[1];
    assign new_pos_c = onp[2];
    assign new_pos_d = onp[3];
    assign final_out = oside_reg.fin;
    assign bad_coord = oside_reg.bad;

    // ---------------- assertions ----------------
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_pos_a) && $stable(bad_coord))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_coord |-> new_pos_a == '0 && new_pos_d == '0)
        else $error("bad item gave nonzero coordinates");
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v2_reg) && $stable(lin2_reg))
        else $error("pipeline moved during stall");

endmodule

FILE: src/sir_stride.sv
// ----------------------------------------------------------------------------
// sir_stride
// Registered row-major strides of a shape, one multiply per slot, modulo 2^64.
// Recomputed continuously; the user must let it settle after configuration writes, before items arrive; not enforced.
// ----------------------------------------------------------------------------
module sir_stride #(
    parameter int MAX_RANK = 4,
    parameter int DIM_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [MAX_RANK-1:0][DIM_BITS-1:0]      size,
    output logic [MAX_RANK-1:0][sir_pkg::LIN_W-1:0] stride
);

    logic [MAX_RANK-1:0][sir_pkg::LIN_W-1:0] stride_reg;
    logic [MAX_RANK-1:0][sir_pkg::LIN_W-1:0] stride_next;

    // Each stride builds on the registered one below, so a chain settles slot
    // by slot with a single multiply between registers.
    always_comb
    begin
        stride_next[MAX_RANK-1] = sir_pkg::LIN_W'(1);
        for (int d = 0; d < MAX_RANK - 1; d++)
        begin
            stride_next[d] = sir_pkg::LIN_W'(stride_reg[d+1]
                             * sir_pkg::LIN_W'(size[d+1]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < MAX_RANK; d++)
                stride_reg[d] <= sir_pkg::LIN_W'(1);
        end
        else
        begin
            stride_reg <= stride_next;
        end
    end

    assign stride = stride_reg;

endmodule

FILE: src/sir_div_stage.sv
// ----------------------------------------------------------------------------
// sir_div_stage
// One restoring-division step on a 64-bit value by a 64-bit divisor. Produces
// one quotient bit; a row of these forms the pipelined divider.
// ----------------------------------------------------------------------------
module sir_div_stage #(
    parameter int BIT = 0
) (
    input  logic [sir_pkg::LIN_W-1:0] rem_in,
    input  logic [sir_pkg::LIN_W-1:0] divisor,
    output logic [sir_pkg::LIN_W-1:0] rem_out,
    output logic                      qbit
);

    logic [2*sir_pkg::LIN_W-1:0] shifted;

    always_comb
    begin
        shifted = (2*sir_pkg::LIN_W)'(divisor) << BIT;
        if ((2*sir_pkg::LIN_W)'(rem_in) >= shifted)
        begin
            qbit    = 1'b1;
            rem_out = sir_pkg::LIN_W'((2*sir_pkg::LIN_W)'(rem_in) - shifted);
        end
        else
        begin
            qbit    = 1'b0;
            rem_out = rem_in;
        end
    end

endmodule

FILE: src/sir_divider.sv
// ----------------------------------------------------------------------------
// sir_divider
// Pipelined 64-bit divider: STEPS_PER_STAGE quotient bits per register stage,
// keeping DIM_BITS low quotient bits. Takes one item per cycle unless stalled.
// ----------------------------------------------------------------------------
module sir_divider #(
    parameter int DIM_BITS        = 16,
    parameter int STEPS_PER_STAGE = 4,
    parameter int PAY_W           = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic [sir_pkg::LIN_W-1:0] in_num,
    input  logic [sir_pkg::LIN_W-1:0] in_div,
    input  logic [PAY_W-1:0]          in_pay,
    output logic                      out_valid,
    output logic [DIM_BITS-1:0]       out_quo,
    output logic [sir_pkg::LIN_W-1:0] out_rem,
    output logic [PAY_W-1:0]          out_pay
);

    localparam int W      = sir_pkg::LIN_W;
    localparam int NSTAGE = (W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int QW     = NSTAGE * STEPS_PER_STAGE;

    logic [NSTAGE:0]            v_reg;
    logic [NSTAGE:0][W-1:0]     rem_reg;
    logic [NSTAGE:0][W-1:0]     div_reg;
    logic [NSTAGE:0][QW-1:0]    quo_reg;
    logic [NSTAGE:0][PAY_W-1:0] pay_reg;
    logic                       zero_div;

    assign v_reg[0]   = in_valid;
    assign rem_reg[0] = in_num;
    assign div_reg[0] = in_div;
    assign quo_reg[0] = '0;
    assign pay_reg[0] = in_pay;

    for (genvar s = 0; s < NSTAGE; s++)
    begin : g_stage
        logic [STEPS_PER_STAGE:0][W-1:0] r;
        logic [STEPS_PER_STAGE-1:0]      q;
        assign r[0] = rem_reg[s];
        for (genvar k = 0; k < STEPS_PER_STAGE; k++)
        begin : g_step
            localparam int B = QW - 1 - s*STEPS_PER_STAGE - k;
            if (B < W)
            begin : g_real
                sir_div_stage #(.BIT(B)) u_step (
                    .rem_in (r[k]),
                    .divisor(div_reg[s]),
                    .rem_out(r[k+1]),
                    .qbit   (q[STEPS_PER_STAGE-1-k])
                );
            end
            else
            begin : g_pad
                assign r[k+1] = r[k];
                assign q[STEPS_PER_STAGE-1-k] = 1'b0;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else if (adv)
                v_reg[s+1] <= v_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s+1] <= r[STEPS_PER_STAGE];
                div_reg[s+1] <= div_reg[s];
                quo_reg[s+1] <= QW'({quo_reg[s], q});
                pay_reg[s+1] <= pay_reg[s];
            end
        end
    end

    // Zero divisor: all-ones quotient, remainder left unchanged.
    assign zero_div  = (div_reg[NSTAGE] == '0);
    assign out_valid = v_reg[NSTAGE];
    assign out_quo   = zero_div ? {DIM_BITS{1'b1}} : quo_reg[NSTAGE][DIM_BITS-1:0];
    assign out_rem   = rem_reg[NSTAGE];
    assign out_pay   = pay_reg[NSTAGE];

endmodule
